[src/ntp_reply_time_fix_assert.svh]
// Assertion macros used by the checker file.
`ifndef NTP_REPLY_TIME_FIX_ASSERT_SVH
`define NTP_REPLY_TIME_FIX_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define NRTF_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define NRTF_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ntprtf_pkg.sv]
package ntprtf_pkg;

	// Stream widths
	localparam int S_DATA_W = 72;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 160;
	localparam int M_USER_W = 2;

	// Word kinds on the input stream
	typedef enum logic [1:0] {
		KIND_SEND    = 2'd0,
		KIND_BYTE    = 2'd1,
		KIND_TIMEOUT = 2'd2
	} kind_t;

	// Result status
	typedef enum logic [1:0] {
		ST_FIX  = 2'd0,
		ST_DROP = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	// Reply layout and checks
	localparam logic [5:0] REPLY_LEN     = 6'd48;
	localparam logic [5:0] COUNT_SAT     = 6'd49;
	localparam logic [5:0] STAMP_FIRST   = 6'd40;
	localparam logic [5:0] IDX_MODE      = 6'd0;
	localparam logic [5:0] IDX_STRATUM   = 6'd1;
	localparam logic [2:0] MODE_SERVER   = 3'd4;
	localparam logic [7:0] STRATUM_LIMIT = 8'd16;

	// Time conversion
	localparam logic signed [32:0] EPOCH_OFFSET_S = 33'sd2208988800;
	localparam logic signed [63:0] NS_PER_S_SW    = 64'sd1000000000;
	localparam logic [29:0]        NS_PER_S       = 30'd1000000000;

endpackage

[src/ntp_reply_time_fix.sv]
// SNTP reply time fix.
// Input stream (s_axis): one word per event. tuser carries the kind (send,
// reply byte, timeout) and the source-ok flag; tdata carries the local
// microsecond time and the reply byte; tlast marks the final reply byte.
// A send word records the send time and arms the wait, a timeout word
// disarms it, and reply bytes are counted and captured. Only a final reply
// byte produces an output word.
// Output stream (m_axis): tuser holds the status, tdata the Unix time in
// nanoseconds, the local midpoint and the round trip time.
// An output word for a final byte passes through the input register, the
// product register and the output register.
// Throughput: one input word per cycle while the later stages have room;
// the two constant multiplies sit in their own stage so the output register only adds.
// A full output register that the receiver stalls does not stop intake:
// the earlier stages keep filling and tready drops only when all are full.
// Reset clears the wait, the byte counter, the captured fields and all
// valid flags; no output word appears until a final byte arrives.
module ntp_reply_time_fix (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [63:0] timestamp_us, [71:64] data_byte
	input  logic [ntprtf_pkg::S_DATA_W-1:0]  s_axis_tdata,
	input  logic                             s_axis_tlast,
	// [1:0] req_type, [2] source_ok
	input  logic [ntprtf_pkg::S_USER_W-1:0]  s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [63:0] unix_ns, [127:64] midpoint_us, [159:128] rtt_us
	output logic [ntprtf_pkg::M_DATA_W-1:0]  m_axis_tdata,
	// [1:0] status
	output logic [ntprtf_pkg::M_USER_W-1:0]  m_axis_tuser
);
	import ntprtf_pkg::*;

	// Block state
	logic        wait_armed_q;
	logic [63:0] send_time_q;
	logic [5:0]  byte_index_q;
	logic [2:0]  mode_bits_q;
	logic [7:0]  stratum_q;
	logic [63:0] stamp_q;

	// Input register
	logic                valid_s1;
	logic [S_DATA_W-1:0] tdata_s1;
	logic [S_USER_W-1:0] tuser_s1;
	logic                tlast_s1;

	// Product stage
	logic        valid_s2;
	status_t     status_s2;
	logic [63:0] secs_ns_s2;
	logic [29:0] frac_ns_s2;
	logic [63:0] mid_s2;
	logic [31:0] rtt_s2;

	// Output register
	logic                out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;
	status_t             out_status_q;

	// Stage 1 decode
	kind_t            kind_s1;
	logic [63:0]      now_s1;
	logic [7:0]       byte_s1;
	logic             src_ok_s1;
	logic [5:0]       idx_next;
	logic [2:0]       mode_next;
	logic [7:0]       stratum_next;
	logic [63:0]      stamp_next;
	logic             result_s1;
	logic             pass_s1;
	logic             good_s1;
	status_t          status_s1;
	logic [63:0]      rtt_full;
	logic signed [32:0] secs_diff;
	logic [63:0]      secs_ns;
	logic [61:0]      frac_prod;

	// Handshake
	logic adv_s1;
	logic adv_s2;
	logic rdy_s2;
	logic fire_s1;

	assign kind_s1   = kind_t'(tuser_s1[1:0]);
	assign src_ok_s1 = tuser_s1[2];
	assign now_s1    = tdata_s1[63:0];
	assign byte_s1   = tdata_s1[71:64];

	// Capture the byte into the header fields and advance the counter
	always_comb begin
		mode_next    = mode_bits_q;
		stratum_next = stratum_q;
		stamp_next   = stamp_q;
		if (byte_index_q == IDX_MODE) begin
			mode_next = byte_s1[2:0];
		end else if (byte_index_q == IDX_STRATUM) begin
			stratum_next = byte_s1;
		end else if (byte_index_q >= STAMP_FIRST && byte_index_q < REPLY_LEN) begin
			stamp_next = {stamp_q[55:0], byte_s1};
		end
		idx_next = (byte_index_q < COUNT_SAT) ? byte_index_q + 6'd1 : byte_index_q;
	end

	// Judge the reply on its final byte
	always_comb begin
		result_s1 = valid_s1 && (kind_s1 == KIND_BYTE) && tlast_s1;
		pass_s1   = wait_armed_q && (idx_next == REPLY_LEN) && src_ok_s1;
		good_s1   = (mode_next == MODE_SERVER) && (stratum_next != 8'd0)
			&& (stratum_next < STRATUM_LIMIT);
		if (!pass_s1) begin
			status_s1 = ST_DROP;
		end else if (!good_s1) begin
			status_s1 = ST_BAD;
		end else begin
			status_s1 = ST_FIX;
		end
	end

	// Round trip and the two constant products
	assign rtt_full  = now_s1 - send_time_q;
	assign secs_diff = $signed({1'b0, stamp_next[63:32]}) - EPOCH_OFFSET_S;
	assign secs_ns   = 64'(64'(secs_diff) * NS_PER_S_SW);
	assign frac_prod = 62'(stamp_next[31:0]) * 62'(NS_PER_S);

	// Stage movement: each stage moves on when the next has room
	assign adv_s2        = valid_s2 && (!out_valid_q || m_axis_tready);
	assign rdy_s2        = !valid_s2 || adv_s2;
	assign adv_s1        = valid_s1 && (!result_s1 || rdy_s2);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign fire_s1       = valid_s1 && adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			tdata_s1 <= s_axis_tdata;
			tuser_s1 <= s_axis_tuser;
			tlast_s1 <= s_axis_tlast;
		end
	end

	// Update the block state as each word leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_armed_q <= 1'b0;
			send_time_q  <= '0;
			byte_index_q <= '0;
			mode_bits_q  <= '0;
			stratum_q    <= '0;
			stamp_q      <= '0;
		end else if (fire_s1) begin
			case (kind_s1)
				KIND_SEND: begin
					send_time_q  <= now_s1;
					wait_armed_q <= 1'b1;
				end
				KIND_TIMEOUT: begin
					wait_armed_q <= 1'b0;
				end
				KIND_BYTE: begin
					mode_bits_q  <= mode_next;
					stratum_q    <= stratum_next;
					stamp_q      <= stamp_next;
					byte_index_q <= tlast_s1 ? 6'd0 : idx_next;
					if (tlast_s1 && status_s1 == ST_FIX) begin
						wait_armed_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Product stage; zero the fields unless a fix is produced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= fire_s1 && result_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && fire_s1 && result_s1) begin
			status_s2 <= status_s1;
			if (status_s1 == ST_FIX) begin
				secs_ns_s2 <= secs_ns;
				frac_ns_s2 <= frac_prod[61:32];
				mid_s2     <= send_time_q + {1'b0, rtt_full[63:1]};
				rtt_s2     <= rtt_full[31:0];
			end else begin
				secs_ns_s2 <= '0;
				frac_ns_s2 <= '0;
				mid_s2     <= '0;
				rtt_s2     <= '0;
			end
		end
	end

	// Output register: add the two products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			out_status_q <= status_s2;
			out_data_q   <= {rtt_s2, mid_s2, secs_ns_s2 + 64'(frac_ns_s2)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

endmodule

[src/ntprtf_checker.sv]
`include "ntp_reply_time_fix_assert.svh"

module ntprtf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [ntprtf_pkg::M_DATA_W-1:0]  m_axis_tdata,
	input logic [ntprtf_pkg::M_USER_W-1:0]  m_axis_tuser
);
	import ntprtf_pkg::*;

	// Hold a stalled output word
	`NRTF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")

	// Status stays within its three codes
	`NRTF_ASSERT_NOW(a_status_code, clk, arst_n, m_axis_tvalid, m_axis_tuser == ST_FIX || m_axis_tuser == ST_DROP || m_axis_tuser == ST_BAD, "unknown status code")

	// A word without a fix carries zero fields
	`NRTF_ASSERT_NOW(a_nofix_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser != ST_FIX, m_axis_tdata == '0, "non-fix word carries data")

	// Intake never stalls while the output register is empty
	`NRTF_ASSERT_NOW(a_ready_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

endmodule

bind ntp_reply_time_fix ntprtf_checker u_ntprtf_checker (.*);
